>>> rtl/core/http_response_header_parser_unit_assert.svh
// Assertion macros shared by the HTTP response header parser RTL.
`ifndef HTTP_RESPONSE_HEADER_PARSER_UNIT_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define HRP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define HRP_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HRP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/hrp_pkg.sv
// Shared types, constants and helper functions of the HTTP response header parser.
package hrp_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned InQueueDepth      = 4;
  localparam int unsigned OutQueueDepth     = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_STATUS   = 2'd0;
  localparam logic [1:0] CFG_MAX_HEADER   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_BODY = 2'd2;
  localparam logic [1:0] CFG_MAX_BODY     = 2'd3;

  localparam logic [15:0] MAX_STATUS_RESET   = 16'd1000;
  localparam logic [15:0] MAX_HEADER_RESET   = 16'd5000;
  localparam logic [31:0] DEFAULT_BODY_RESET = 32'd5000;
  localparam logic [31:0] MAX_BODY_RESET     = 32'd10000;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [3:0] NAME_LEN = 4'd14;

  localparam logic ITEM_SUMMARY = 1'b0;
  localparam logic ITEM_BODY    = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  body_byte;
    logic        body_last;
    logic [31:0] content_length;
    logic        length_found;
    logic [15:0] status_length;
    logic [7:0]  header_count;
    logic        headers_truncated;
  } out_item_t;

  // A byte with its character classes worked out by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_blank;
    logic       is_plus;
    logic       is_minus;
  } byte_class_t;

  // Characters of the header name "Content-Length".
  function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/hrp_fifo.sv
// Small register-based queue used between the parser stages.
`include "http_response_header_parser_unit_assert.svh"

module hrp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `HRP_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(DEPTH), "queue count above depth")
  `HRP_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "lost push")
  `HRP_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "lost pop")

endmodule

>>> rtl/core/hrp_front.sv
// Front end: accepts stream bytes and sorts them into character classes.
module hrp_front
  import hrp_pkg::*;
(
  input  logic        push_i,
  input  in_item_t    item_i,
  output logic        full_o,
  input  logic        q_full_i,
  output logic        q_push_o,
  output byte_class_t q_item_o
);

  logic [7:0] b;

  assign b        = item_i.data_byte;
  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    q_item_o            = '0;
    q_item_o.data_byte  = b;
    q_item_o.stream_end = item_i.stream_end;
    q_item_o.is_cr      = (b == CHAR_CR);
    q_item_o.is_lf      = (b == CHAR_LF);
    q_item_o.is_colon   = (b == CHAR_COLON);
    q_item_o.is_digit   = b inside {[CHAR_ZERO:CHAR_NINE]};
    q_item_o.digit      = 4'(b - CHAR_ZERO);
    q_item_o.is_blank   = b inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
    q_item_o.is_plus    = (b == CHAR_PLUS);
    q_item_o.is_minus   = (b == CHAR_MINUS);
  end

endmodule

>>> rtl/core/hrp_back.sv
// Back end: status line, header and body sequencing, and result formation.
`include "http_response_header_parser_unit_assert.svh"

module hrp_back
  import hrp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        q_empty_i,
  input  byte_class_t q_item_i,
  output logic        q_pop_o,
  input  logic        out_full_i,
  output logic        out_push_o,
  output out_item_t   out_item_o
);

  localparam int unsigned LB    = LENGTH_BITS;
  localparam int unsigned WideW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  localparam logic [1:0] PH_STATUS = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [15:0] max_status_q, max_header_q;
  logic [31:0] default_body_q, max_body_q;

  logic [1:0]    phase_q, phase_d;
  logic          prev_cr_q, prev_cr_d;
  logic [15:0]   status_cnt_q, status_cnt_d;
  logic [15:0]   hdr_cnt_q, hdr_cnt_d;
  logic [7:0]    lines_q, lines_d;
  logic          line_empty_q, line_empty_d;
  logic          colon_q, colon_d;
  logic [3:0]    name_idx_q, name_idx_d;
  logic          name_ok_q, name_ok_d;
  logic [LB-1:0] acc_q, acc_d;
  logic          digits_done_q, digits_done_d;
  logic          started_q, started_d;
  logic          negative_q, negative_d;
  logic          len_seen_q, len_seen_d;
  logic [LB-1:0] parsed_q, parsed_d;
  logic [31:0]   body_rem_q, body_rem_d;

  logic          fire;
  logic          crlf;
  logic [15:0]   status_inc, hdr_inc, status_limit, hdr_limit;
  logic [LB+3:0] acc_ext, acc_mul;
  logic [LB-1:0] acc_digit;
  logic          cl_hit;
  logic          sum_len_seen;
  logic [LB-1:0] sum_parsed;
  logic [WideW-1:0] len_raw, len_w;
  logic [31:0]   sum_cl, sum_rem;
  logic          emit, emit_trunc;

  assign cfg_ready_o = 1'b1;
  assign fire        = !q_empty_i && !out_full_i;
  assign q_pop_o     = fire;
  assign crlf        = q_item_i.is_lf && prev_cr_q;

  assign status_inc   = status_cnt_q + 16'd1;
  assign hdr_inc      = hdr_cnt_q + 16'd1;
  assign status_limit = (max_status_q == '0) ? 16'd1 : max_status_q;
  assign hdr_limit    = (max_header_q == '0) ? 16'd1 : max_header_q;

  // Decimal accumulate as shift-and-add, saturating at the length maximum.
  assign acc_ext   = (LB + 4)'(acc_q);
  assign acc_mul   = (acc_ext << 3) + (acc_ext << 1) + (LB + 4)'(q_item_i.digit);
  assign acc_digit = (acc_mul[LB+3:LB] != '0) ? '1 : acc_mul[LB-1:0];

  // A completed line named exactly Content-Length updates the parsed length.
  assign cl_hit       = crlf && !line_empty_q && colon_q && name_ok_q
                        && (name_idx_q == NAME_LEN);
  assign sum_len_seen = len_seen_q || cl_hit;
  assign sum_parsed   = cl_hit ? (negative_q ? '0 : acc_q) : parsed_q;

  always_comb begin
    len_raw = sum_len_seen ? WideW'(sum_parsed) : WideW'(default_body_q);
    len_w   = (len_raw > WideW'({LB{1'b1}})) ? WideW'({LB{1'b1}}) : len_raw;
    sum_cl  = (len_w > WideW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len_w[31:0];
    sum_rem = (len_w < WideW'(max_body_q)) ? len_w[31:0] : max_body_q;
  end

  always_comb begin
    phase_d       = phase_q;
    prev_cr_d     = prev_cr_q;
    status_cnt_d  = status_cnt_q;
    hdr_cnt_d     = hdr_cnt_q;
    lines_d       = lines_q;
    line_empty_d  = line_empty_q;
    colon_d       = colon_q;
    name_idx_d    = name_idx_q;
    name_ok_d     = name_ok_q;
    acc_d         = acc_q;
    digits_done_d = digits_done_q;
    started_d     = started_q;
    negative_d    = negative_q;
    len_seen_d    = len_seen_q;
    parsed_d      = parsed_q;
    body_rem_d    = body_rem_q;
    emit          = 1'b0;
    emit_trunc    = 1'b0;
    out_push_o    = 1'b0;
    out_item_o    = '0;

    if (fire) begin
      if (q_item_i.stream_end) begin
        phase_d       = PH_STATUS;
        prev_cr_d     = 1'b0;
        status_cnt_d  = '0;
        hdr_cnt_d     = '0;
        lines_d       = '0;
        line_empty_d  = 1'b1;
        colon_d       = 1'b0;
        name_idx_d    = '0;
        name_ok_d     = 1'b1;
        acc_d         = '0;
        digits_done_d = 1'b0;
        started_d     = 1'b0;
        negative_d    = 1'b0;
        len_seen_d    = 1'b0;
        parsed_d      = '0;
        body_rem_d    = '0;
      end else begin
        case (phase_q)
          PH_STATUS: begin
            if (crlf) begin
              // The CR LF pair is not part of the status length.
              status_cnt_d = status_cnt_q - 16'd1;
              phase_d      = PH_HEADER;
              prev_cr_d    = 1'b0;
            end else if (status_inc >= status_limit) begin
              status_cnt_d = status_inc;
              phase_d      = PH_HEADER;
              prev_cr_d    = 1'b0;
            end else begin
              status_cnt_d = status_inc;
              prev_cr_d    = q_item_i.is_cr;
            end
          end
          PH_HEADER: begin
            hdr_cnt_d = hdr_inc;
            if (crlf && line_empty_q) begin
              emit = 1'b1;
            end else begin
              if (crlf) begin
                if (lines_q != 8'hFF) begin
                  lines_d = lines_q + 8'd1;
                end
                len_seen_d    = sum_len_seen;
                parsed_d      = sum_parsed;
                line_empty_d  = 1'b1;
                colon_d       = 1'b0;
                name_idx_d    = '0;
                name_ok_d     = 1'b1;
                acc_d         = '0;
                digits_done_d = 1'b0;
                started_d     = 1'b0;
                negative_d    = 1'b0;
                prev_cr_d     = 1'b0;
              end else begin
                if (!colon_q) begin
                  if (q_item_i.is_colon) begin
                    colon_d = 1'b1;
                  end else if (name_ok_q && (name_idx_q < NAME_LEN)
                               && (q_item_i.data_byte == cl_name_char(name_idx_q))) begin
                    name_idx_d = name_idx_q + 4'd1;
                  end else begin
                    name_ok_d = 1'b0;
                  end
                end else if (!digits_done_q) begin
                  if (q_item_i.is_digit) begin
                    started_d = 1'b1;
                    acc_d     = acc_digit;
                  end else if (!started_q && q_item_i.is_blank) begin
                    // Leading blanks before the number are skipped.
                  end else if (!started_q && (q_item_i.is_plus || q_item_i.is_minus)) begin
                    started_d  = 1'b1;
                    negative_d = q_item_i.is_minus;
                  end else begin
                    digits_done_d = 1'b1;
                  end
                end
                line_empty_d = line_empty_q && q_item_i.is_cr && !prev_cr_q;
                prev_cr_d    = q_item_i.is_cr;
              end
              if (hdr_inc >= hdr_limit) begin
                emit       = 1'b1;
                emit_trunc = 1'b1;
              end
            end
          end
          PH_BODY: begin
            body_rem_d                = body_rem_q - 32'd1;
            out_push_o                = 1'b1;
            out_item_o.item_kind      = ITEM_BODY;
            out_item_o.body_byte      = q_item_i.data_byte;
            out_item_o.body_last      = (body_rem_q == 32'd1);
            if (body_rem_q == 32'd1) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            // Bytes after the body are dropped until the stream ends.
          end
        endcase

        if (emit) begin
          body_rem_d                   = sum_rem;
          phase_d                      = (sum_rem == '0) ? PH_DONE : PH_BODY;
          out_push_o                   = 1'b1;
          out_item_o.item_kind         = ITEM_SUMMARY;
          out_item_o.body_last         = (sum_rem == '0);
          out_item_o.content_length    = sum_cl;
          out_item_o.length_found      = sum_len_seen;
          out_item_o.status_length     = status_cnt_q;
          out_item_o.header_count      = lines_d;
          out_item_o.headers_truncated = emit_trunc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_status_q   <= MAX_STATUS_RESET;
      max_header_q   <= MAX_HEADER_RESET;
      default_body_q <= DEFAULT_BODY_RESET;
      max_body_q     <= MAX_BODY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAX_STATUS:   max_status_q   <= cfg_data_i[15:0];
        CFG_MAX_HEADER:   max_header_q   <= cfg_data_i[15:0];
        CFG_DEFAULT_BODY: default_body_q <= cfg_data_i;
        CFG_MAX_BODY:     max_body_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_STATUS;
      prev_cr_q     <= 1'b0;
      status_cnt_q  <= '0;
      hdr_cnt_q     <= '0;
      lines_q       <= '0;
      line_empty_q  <= 1'b1;
      colon_q       <= 1'b0;
      name_idx_q    <= '0;
      name_ok_q     <= 1'b1;
      acc_q         <= '0;
      digits_done_q <= 1'b0;
      started_q     <= 1'b0;
      negative_q    <= 1'b0;
      len_seen_q    <= 1'b0;
      parsed_q      <= '0;
      body_rem_q    <= '0;
    end else begin
      phase_q       <= phase_d;
      prev_cr_q     <= prev_cr_d;
      status_cnt_q  <= status_cnt_d;
      hdr_cnt_q     <= hdr_cnt_d;
      lines_q       <= lines_d;
      line_empty_q  <= line_empty_d;
      colon_q       <= colon_d;
      name_idx_q    <= name_idx_d;
      name_ok_q     <= name_ok_d;
      acc_q         <= acc_d;
      digits_done_q <= digits_done_d;
      started_q     <= started_d;
      negative_q    <= negative_d;
      len_seen_q    <= len_seen_d;
      parsed_q      <= parsed_d;
      body_rem_q    <= body_rem_d;
    end
  end

  `HRP_ASSERT_IMPLIES(a_body_nonzero, phase_q == PH_BODY, body_rem_q != '0, "body phase with no bytes left")
  `HRP_ASSERT_IMPLIES(a_no_push_full, out_push_o, !out_full_i, "result pushed into full queue")
  `HRP_ASSERT_IMPLIES(a_status_clean, phase_q == PH_STATUS, (lines_q == '0) && !len_seen_q, "header state left over in status phase")

endmodule

>>> rtl/core/http_response_header_parser_unit.sv
// Throughput: one byte per cycle while the output queue is not full, set by the
// per-byte update in the back end.
// The input queue holds 4 classified bytes and the output queue 2 results, so each side
// may stall on its own; full rises only when the input queue is full.
// Reset (rst_ni low, asynchronous) empties both queues, returns to the status line and
// loads the configuration registers with their default values.
module http_response_header_parser_unit
  import hrp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  in_item_t    in_item_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic        iq_push, iq_full, iq_empty, iq_pop;
  byte_class_t iq_wdata, iq_rdata;
  logic        oq_push, oq_full;
  out_item_t   oq_wdata;

  hrp_front u_front (
    .push_i   (push),
    .item_i   (in_item_i),
    .full_o   (full),
    .q_full_i (iq_full),
    .q_push_o (iq_push),
    .q_item_o (iq_wdata)
  );

  hrp_fifo #(
    .WIDTH ($bits(byte_class_t)),
    .DEPTH (InQueueDepth)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (iq_push),
    .data_i  (iq_wdata),
    .full_o  (iq_full),
    .pop_i   (iq_pop),
    .data_o  (iq_rdata),
    .empty_o (iq_empty)
  );

  hrp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (iq_empty),
    .q_item_i    (iq_rdata),
    .q_pop_o     (iq_pop),
    .out_full_i  (oq_full),
    .out_push_o  (oq_push),
    .out_item_o  (oq_wdata)
  );

  hrp_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OutQueueDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_wdata),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule
